// ===== rtl/core/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// Smallest prime factor sieve package
// Shared widths, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned ENTRY_BITS  = 8;
  localparam int unsigned IDX_BITS    = VALUE_BITS - 1;
  localparam int unsigned TABLE_DEPTH = 1 << IDX_BITS;
  localparam int unsigned P_BITS      = VALUE_BITS / 2 + 1;
  localparam int unsigned SQ_BITS     = VALUE_BITS + 1;

  localparam logic [VALUE_BITS-1:0] MAX_VALUE_RESET = '1;

  localparam logic [P_BITS-1:0]  FIRST_PRIME = P_BITS'(3);
  localparam logic [SQ_BITS-1:0] FIRST_SQ    = SQ_BITS'(9);

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_DATA,
    ST_B_PCHK,
    ST_B_PWAIT,
    ST_B_MCHK,
    ST_B_MWAIT
  } state_e;

endpackage

// ===== rtl/core/smallest_prime_factor_sieve.sv =====
// ----------------------------------------------------------------------------
// Smallest prime factor sieve
// Table of smallest odd prime factors, built by a sieve walk and queried.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: value[15:0]; tuser: cmd (0 build, 1 query)
//  m_axis    out        tdata: factor[15:0]; tuser: build_done
//  cfg       in         cfg_data_i: max_value[15:0]
//
// After reset a clearing pass writes zero to all 32768 table entries, one per
// cycle, and no beat is accepted meanwhile. A query result is taken from the
// registered read port of the table into the output register. A build reads
// each odd candidate p; for each prime p it visits the multiples from p*p up
// in steps of 2p, reading each and writing p where the entry is still zero,
// and finally acknowledges with a build_done beat. A result waits while
// the output register holds an unaccepted beat, and the next input beat is
// accepted once the result sits in the output register.
module smallest_prime_factor_sieve (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sps_pkg::VALUE_BITS-1:0] s_axis_tdata,  // value
  input  logic                           s_axis_tuser,  // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sps_pkg::VALUE_BITS-1:0] m_axis_tdata,  // factor
  output logic                           m_axis_tuser,  // build_done
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sps_pkg::VALUE_BITS-1:0] cfg_data_i
);

  sps_pkg::state_e state_q, state_d;

  logic [sps_pkg::VALUE_BITS-1:0] max_value_q;
  logic [sps_pkg::IDX_BITS-1:0]   clr_idx_q, clr_idx_d;
  logic [sps_pkg::VALUE_BITS-1:0] value_q, value_d;
  logic [sps_pkg::P_BITS-1:0]     p_q, p_d;
  logic [sps_pkg::SQ_BITS-1:0]    sq_q, sq_d;
  logic [sps_pkg::SQ_BITS-1:0]    m_q, m_d;

  logic                           out_valid_q, out_valid_d;
  logic [sps_pkg::VALUE_BITS-1:0] out_factor_q, out_factor_d;
  logic                           out_done_q, out_done_d;
  logic                           out_free;

  logic [sps_pkg::ENTRY_BITS-1:0] mem_q [sps_pkg::TABLE_DEPTH];
  logic [sps_pkg::ENTRY_BITS-1:0] rdata_q;
  logic                           rd_en;
  logic [sps_pkg::IDX_BITS-1:0]   rd_addr;
  logic                           wr_en;
  logic [sps_pkg::IDX_BITS-1:0]   wr_addr;
  logic [sps_pkg::ENTRY_BITS-1:0] wr_data;

  logic [sps_pkg::SQ_BITS-1:0]    limit;
  logic [sps_pkg::SQ_BITS-1:0]    p_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == sps_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_factor_q;
  assign m_axis_tuser  = out_done_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign limit    = {1'b0, max_value_q};
  assign p_ext    = sps_pkg::SQ_BITS'(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sps_pkg::ST_CLEAR;
      max_value_q <= sps_pkg::MAX_VALUE_RESET;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_value_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    p_q          <= p_d;
    sq_q         <= sq_d;
    m_q          <= m_d;
    out_factor_q <= out_factor_d;
    out_done_q   <= out_done_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    value_d      = value_q;
    p_d          = p_q;
    sq_d         = sq_q;
    m_d          = m_q;
    out_factor_d = out_factor_q;
    out_done_d   = out_done_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    rd_en        = 1'b0;
    rd_addr      = m_q[sps_pkg::IDX_BITS:1];
    wr_en        = 1'b0;
    wr_addr      = m_q[sps_pkg::IDX_BITS:1];
    wr_data      = p_q[sps_pkg::ENTRY_BITS-1:0];

    case (state_q)
      sps_pkg::ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_idx_q;
        wr_data   = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          state_d = sps_pkg::ST_IDLE;
        end
      end
      sps_pkg::ST_IDLE: begin
        rd_addr = s_axis_tdata[sps_pkg::IDX_BITS:1];
        if (s_axis_tvalid) begin
          value_d = s_axis_tdata;
          p_d     = sps_pkg::FIRST_PRIME;
          sq_d    = sps_pkg::FIRST_SQ;
          if (s_axis_tuser == sps_pkg::CMD_QUERY) begin
            rd_en   = 1'b1;
            state_d = sps_pkg::ST_Q_DATA;
          end else begin
            state_d = sps_pkg::ST_B_PCHK;
          end
        end
      end
      sps_pkg::ST_Q_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_done_d  = 1'b0;
          if (!value_q[0]) begin
            out_factor_d = sps_pkg::VALUE_BITS'(2);
          end else if (rdata_q == '0) begin
            out_factor_d = value_q;
          end else begin
            out_factor_d = sps_pkg::VALUE_BITS'(rdata_q);
          end
          state_d = sps_pkg::ST_IDLE;
        end
      end
      sps_pkg::ST_B_PCHK: begin
        rd_addr = sps_pkg::IDX_BITS'(p_q[sps_pkg::P_BITS-1:1]);
        if (sq_q > limit) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_done_d   = 1'b1;
            out_factor_d = '0;
            state_d      = sps_pkg::ST_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = sps_pkg::ST_B_PWAIT;
        end
      end
      sps_pkg::ST_B_PWAIT: begin
        if (rdata_q != '0) begin
          p_d     = p_q + sps_pkg::P_BITS'(2);
          sq_d    = sq_q + {p_ext[sps_pkg::SQ_BITS-3:0], 2'b00} + sps_pkg::SQ_BITS'(4);
          state_d = sps_pkg::ST_B_PCHK;
        end else begin
          m_d     = sq_q;
          state_d = sps_pkg::ST_B_MCHK;
        end
      end
      sps_pkg::ST_B_MCHK: begin
        if (m_q > limit) begin
          p_d     = p_q + sps_pkg::P_BITS'(2);
          sq_d    = sq_q + {p_ext[sps_pkg::SQ_BITS-3:0], 2'b00} + sps_pkg::SQ_BITS'(4);
          state_d = sps_pkg::ST_B_PCHK;
        end else begin
          rd_en   = 1'b1;
          state_d = sps_pkg::ST_B_MWAIT;
        end
      end
      sps_pkg::ST_B_MWAIT: begin
        wr_en   = (rdata_q == '0);
        m_d     = m_q + {p_ext[sps_pkg::SQ_BITS-2:0], 1'b0};
        state_d = sps_pkg::ST_B_MCHK;
      end
      default: begin
        state_d = sps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
